[rtl/core/schroeder_reverb_fixed_unit_defines.svh]
// assertion macros for the reverberator core
`ifndef SCHROEDER_REVERB_FIXED_UNIT_DEFINES_SVH
`define SCHROEDER_REVERB_FIXED_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/srf_pkg.sv]
// shared widths, register codes, reset values, gain table and arithmetic helpers
package srf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SAMP_W     = 24;
    localparam int DRY_W      = 19;
    localparam int RND_W      = 26;
    localparam int SUM_W      = 28;
    localparam int MULA_W     = 24;
    localparam int MULB_W     = 18;
    localparam int PROD_W     = MULA_W + MULB_W;
    localparam int MIX_W      = 43;
    localparam int DLY_W      = 12;
    localparam int GAIN_W     = 16;
    localparam int WET_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int MAX_DELAY_DEF = 4096;
    localparam int NUM_COMBS_DEF = 4;
    localparam int NUM_DIFF_DEF  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COMB_DELAY_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMB_DELAY_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMB_DELAY_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMB_DELAY_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_DELAY_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_DELAY_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_LEVEL    = 3'd7;

    localparam logic [DLY_W-1:0] RST_COMB_DELAY [4] = '{12'd1309, 12'd793, 12'd1984, 12'd2646};
    localparam logic [DLY_W-1:0] RST_DIFF_DELAY [2] = '{12'd220, 12'd74};
    localparam logic [GAIN_W-1:0] RST_DIFF_GAIN     = 16'd45875;
    localparam logic [WET_W-1:0]  RST_WET_LEVEL     = 17'd32768;
    localparam logic [WET_W-1:0]  WET_ONE           = 17'd65536;

    // fixed comb feedback gains as fractions of 65536
    localparam logic [GAIN_W-1:0] COMB_GAIN [4] = '{16'd52756, 16'd54198, 16'd51315, 16'd50070};

    // saturate to the internal sample range
    function automatic logic signed [SAMP_W-1:0] f_sat24(input logic signed [SUM_W-1:0] v);
        if (v > 28'sd8388607) begin
            return {1'b0, {(SAMP_W-1){1'b1}}};
        end else if (v < -28'sd8388608) begin
            return {1'b1, {(SAMP_W-1){1'b0}}};
        end else begin
            return v[SAMP_W-1:0];
        end
    endfunction

    // gain product back to sample scale, round to nearest, ties upward
    function automatic logic signed [RND_W-1:0] f_round_gain(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + 42'sd32768;
        return t[PROD_W-1:16];
    endfunction

endpackage

[rtl/core/srf_ram.sv]
// generic simple dual-port ram with registered read
module srf_ram #(
    parameter int WIDTH = srf_pkg::SAMP_W,
    parameter int DEPTH = srf_pkg::MAX_DELAY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/schroeder_reverb_fixed_unit.sv]
// schroeder reverberator core: comb bank, diffusion chain and dry/wet mix on one multiplier
// the comb average needs an extra divide step when NUM_COMBS is not a power of two
// one sample at a time: a new input is accepted only in idle, once the last result has been
//   loaded into the output register; this is set by the single shared multiplier
//   and the one read port of each delay-line memory
// reset: synchronous, no clearing pass; entries not yet written since reset read as zero
`include "schroeder_reverb_fixed_unit_defines.svh"

module schroeder_reverb_fixed_unit #(
    parameter int MAX_DELAY     = srf_pkg::MAX_DELAY_DEF,
    parameter int NUM_COMBS     = srf_pkg::NUM_COMBS_DEF,
    parameter int NUM_DIFFUSERS = srf_pkg::NUM_DIFF_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [srf_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [srf_pkg::SAMPLE_W-1:0]    m_axis_tdata,   // [15:0] sample_out
    input  logic                            i_cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW        = $clog2(MAX_DELAY);
    localparam int AW1       = AW + 1;
    localparam int KW        = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
    localparam int JW        = (NUM_DIFFUSERS > 1) ? $clog2(NUM_DIFFUSERS) : 1;
    localparam int COMB_DEPTH = 2 ** (KW + AW);
    localparam int DIFF_DEPTH = 2 ** (JW + AW);
    localparam int CLOG_C    = $clog2(NUM_COMBS);
    localparam int UW        = srf_pkg::SAMP_W + CLOG_C;
    localparam int SW        = UW + 1;
    localparam int DHW       = UW - 14;
    localparam logic [15:0] DIV_RHI = 16'((2 ** 14) % NUM_COMBS);
    localparam logic [srf_pkg::SAMP_W-1:0] DIV_QHI = srf_pkg::SAMP_W'((2 ** 14) / NUM_COMBS);
    localparam logic signed [srf_pkg::MULA_W-1:0] DIV_RECIP =
        srf_pkg::MULA_W'((2 ** 20 + NUM_COMBS - 1) / NUM_COMBS);
    localparam bit C_POW2    = (NUM_COMBS & (NUM_COMBS - 1)) == 0;
    localparam logic signed [SW-1:0] AVG_BIAS = SW'(NUM_COMBS / 2 + NUM_COMBS * (2 ** 23));
    localparam int SAMP_W    = srf_pkg::SAMP_W;
    localparam int MIX_W     = srf_pkg::MIX_W;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_CRD   = 14'b00000000000010,
        S_CMUL  = 14'b00000000000100,
        S_CACC  = 14'b00000000001000,
        S_DIVLD = 14'b00000000010000,
        S_DIV   = 14'b00000000100000,
        S_DRD   = 14'b00000001000000,
        S_DM1   = 14'b00000010000000,
        S_DM2   = 14'b00000100000000,
        S_DWR   = 14'b00001000000000,
        S_MX1   = 14'b00010000000000,
        S_MX2   = 14'b00100000000000,
        S_MX3   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    // control
    t_state           r_state;
    logic [KW-1:0]    r_k;
    logic [JW-1:0]    r_j;
    logic [AW-1:0]    r_wp;
    logic             r_wrapped;
    logic             r_out_valid;

    // configuration
    logic [srf_pkg::DLY_W-1:0]  r_comb_delay [4];
    logic [srf_pkg::DLY_W-1:0]  r_diff_delay [2];
    logic [srf_pkg::GAIN_W-1:0] r_diff_gain;
    logic [srf_pkg::WET_W-1:0]  r_wet_level;

    // datapath
    logic signed [srf_pkg::DRY_W-1:0]  r_dry;
    logic signed [SW-1:0]              r_sum;
    logic signed [SAMP_W-1:0]          r_wet;
    logic signed [srf_pkg::RND_W-1:0]  r_acc;
    logic signed [srf_pkg::PROD_W-1:0] r_prod;
    logic signed [MIX_W-1:0]           r_mix;
    logic                              r_rd_valid;
    logic [srf_pkg::SAMPLE_W-1:0]      r_out_data;

    logic signed [srf_pkg::PROD_W-1:0] n_prod;
    logic [DHW-1:0]                    div_hi;
    logic [13:0]                       div_lo;
    logic [15:0]                       div_t;
    logic [SAMP_W-1:0]                 div_q;

    logic signed [srf_pkg::MULA_W-1:0] mul_a;
    logic signed [srf_pkg::MULB_W-1:0] mul_b;

    logic [srf_pkg::DLY_W-1:0] sel_delay;
    logic [19:0]               dly_t;
    logic [AW-1:0]             dm;
    logic [AW1-1:0]            rd_t;
    logic [AW-1:0]             rd_idx;
    logic                      rd_ok;

    logic signed [SAMP_W-1:0]  comb_rdata;
    logic signed [SAMP_W-1:0]  dout_rdata;
    logic signed [SAMP_W-1:0]  din_rdata;
    logic signed [SAMP_W-1:0]  comb_y;
    logic signed [SAMP_W-1:0]  diff_y;

    logic signed [SW-1:0]      avg_s;
    logic [UW-1:0]             avg_u;
    logic [SAMP_W-1:0]         avg_q;

    logic [srf_pkg::WET_W-1:0] wet_w;
    logic signed [MIX_W-1:0]   mix_adj;
    logic signed [MIX_W-20:0]  mix_q;
    logic [srf_pkg::SAMPLE_W-1:0] out_sat;
    logic                      out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // read index into the delay lines, shared by combs and diffusers
    always_comb begin
        sel_delay = (r_state == S_DRD) ? r_diff_delay[r_j[0]] : r_comb_delay[2'(r_k)];
        dly_t = 20'(sel_delay);
        for (int s = 3; s >= 0; s--) begin
            if (dly_t >= 20'(MAX_DELAY << s)) begin
                dly_t = dly_t - 20'(MAX_DELAY << s);
            end
        end
        dm = AW'(dly_t);
        rd_t = AW1'(r_wp) + AW1'(MAX_DELAY) - AW1'(dm);
        if (rd_t >= AW1'(MAX_DELAY)) begin
            rd_t = rd_t - AW1'(MAX_DELAY);
        end
        rd_idx = rd_t[AW-1:0];
        rd_ok  = r_wrapped || (rd_idx < r_wp);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_CMUL: begin
                mul_a = r_rd_valid ? comb_rdata : '0;
                mul_b = {2'b00, srf_pkg::COMB_GAIN[2'(r_k)]};
            end
            S_DIVLD: begin
                mul_a = DIV_RECIP;
                mul_b = {2'b00, div_t};
            end
            S_DM1: begin
                mul_a = r_rd_valid ? dout_rdata : '0;
                mul_b = {2'b00, r_diff_gain};
            end
            S_DM2: begin
                mul_a = r_rd_valid ? din_rdata : '0;
                mul_b = {2'b00, r_diff_gain};
            end
            S_MX1: begin
                mul_a = SAMP_W'(r_dry);
                mul_b = {1'b0, srf_pkg::WET_ONE - wet_w};
            end
            S_MX2: begin
                mul_a = r_wet;
                mul_b = {1'b0, wet_w};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = mul_a * mul_b;
    end

    // comb average by reciprocal: high part times 2^14/N, folded low part on the multiplier
    assign div_hi = avg_u[UW-1:14];
    assign div_lo = avg_u[13:0];
    assign div_t  = 16'(div_hi) * DIV_RHI + 16'(div_lo);
    assign div_q  = SAMP_W'(div_hi) * DIV_QHI + SAMP_W'(r_prod[20 +: 16]);

    assign comb_y = srf_pkg::f_sat24(srf_pkg::SUM_W'(r_dry)
                    + srf_pkg::SUM_W'(srf_pkg::f_round_gain(r_prod)));
    assign diff_y = srf_pkg::f_sat24(srf_pkg::SUM_W'(r_acc)
                    - srf_pkg::SUM_W'(srf_pkg::f_round_gain(r_prod)));

    assign avg_s = r_sum + AVG_BIAS;
    assign avg_u = avg_s[UW-1:0];
    assign avg_q = avg_u[CLOG_C +: SAMP_W];

    assign wet_w = (r_wet_level > srf_pkg::WET_ONE) ? srf_pkg::WET_ONE : r_wet_level;

    // truncate toward zero to q1.15 and clamp
    always_comb begin
        mix_adj = r_mix[MIX_W-1] ? (r_mix + MIX_W'(2 ** 19 - 1)) : r_mix;
        mix_q   = mix_adj[MIX_W-1:19];
        if (mix_q > 24'sd32767) begin
            out_sat = 16'h7FFF;
        end else if (mix_q < -24'sd32768) begin
            out_sat = 16'h8000;
        end else begin
            out_sat = mix_q[srf_pkg::SAMPLE_W-1:0];
        end
    end

    // sequencer and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_j          <= '0;
            r_wp         <= '0;
            r_wrapped    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_comb_delay <= srf_pkg::RST_COMB_DELAY;
            r_diff_delay <= srf_pkg::RST_DIFF_DELAY;
            r_diff_gain  <= srf_pkg::RST_DIFF_GAIN;
            r_wet_level  <= srf_pkg::RST_WET_LEVEL;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    srf_pkg::CFG_COMB_DELAY_A: r_comb_delay[0] <= i_cfg_data[srf_pkg::DLY_W-1:0];
                    srf_pkg::CFG_COMB_DELAY_B: r_comb_delay[1] <= i_cfg_data[srf_pkg::DLY_W-1:0];
                    srf_pkg::CFG_COMB_DELAY_C: r_comb_delay[2] <= i_cfg_data[srf_pkg::DLY_W-1:0];
                    srf_pkg::CFG_COMB_DELAY_D: r_comb_delay[3] <= i_cfg_data[srf_pkg::DLY_W-1:0];
                    srf_pkg::CFG_DIFF_DELAY_A: r_diff_delay[0] <= i_cfg_data[srf_pkg::DLY_W-1:0];
                    srf_pkg::CFG_DIFF_DELAY_B: r_diff_delay[1] <= i_cfg_data[srf_pkg::DLY_W-1:0];
                    srf_pkg::CFG_DIFF_GAIN:    r_diff_gain <= i_cfg_data[srf_pkg::GAIN_W-1:0];
                    srf_pkg::CFG_WET_LEVEL:    r_wet_level <= i_cfg_data;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_k     <= '0;
                        r_state <= S_CRD;
                    end
                end
                S_CRD:  r_state <= S_CMUL;
                S_CMUL: r_state <= S_CACC;
                S_CACC: begin
                    if (r_k == KW'(NUM_COMBS - 1)) begin
                        r_state <= S_DIVLD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_DIVLD: begin
                    r_j     <= '0;
                    r_state <= C_POW2 ? S_DRD : S_DIV;
                end
                S_DIV: r_state <= S_DRD;
                S_DRD: r_state <= S_DM1;
                S_DM1: r_state <= S_DM2;
                S_DM2: r_state <= S_DWR;
                S_DWR: begin
                    if (r_j == JW'(NUM_DIFFUSERS - 1)) begin
                        r_state <= S_MX1;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_MX1: r_state <= S_MX2;
                S_MX2: r_state <= S_MX3;
                S_MX3: r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                        if (r_wp == AW'(MAX_DELAY - 1)) begin
                            r_wp      <= '0;
                            r_wrapped <= 1'b1;
                        end else begin
                            r_wp <= r_wp + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (s_axis_tvalid && s_axis_tready) begin
            r_dry <= {s_axis_tdata, 3'b000};
            r_sum <= '0;
        end
        if (r_state == S_CRD || r_state == S_DRD) begin
            r_rd_valid <= rd_ok;
        end
        if (r_state == S_CACC) begin
            r_sum <= r_sum + SW'(comb_y);
        end
        if (r_state == S_DIVLD) begin
            if (C_POW2) begin
                r_wet <= {~avg_q[SAMP_W-1], avg_q[SAMP_W-2:0]};
            end
        end
        if (r_state == S_DIV) begin
            r_wet <= {~div_q[SAMP_W-1], div_q[SAMP_W-2:0]};
        end
        if (r_state == S_DM2) begin
            r_acc <= srf_pkg::RND_W'(r_wet) + srf_pkg::f_round_gain(r_prod);
        end
        if (r_state == S_DWR) begin
            r_wet <= diff_y;
        end
        if (r_state == S_MX2) begin
            r_mix <= MIX_W'(r_prod);
        end
        if (r_state == S_MX3) begin
            r_mix <= r_mix + MIX_W'(r_prod);
        end
        if (out_load) begin
            r_out_data <= out_sat;
        end
    end

    // comb delay lines
    srf_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (COMB_DEPTH)
    ) u_comb_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CACC),
        .i_waddr ({r_k, r_wp}),
        .i_wdata (comb_y),
        .i_re    (r_state == S_CRD),
        .i_raddr ({r_k, rd_idx}),
        .o_rdata (comb_rdata)
    );

    // diffuser output history
    srf_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (DIFF_DEPTH)
    ) u_dout_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_DWR),
        .i_waddr ({r_j, r_wp}),
        .i_wdata (diff_y),
        .i_re    (r_state == S_DRD),
        .i_raddr ({r_j, rd_idx}),
        .o_rdata (dout_rdata)
    );

    // diffuser input history
    srf_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (DIFF_DEPTH)
    ) u_din_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_DWR),
        .i_waddr ({r_j, r_wp}),
        .i_wdata (r_wet),
        .i_re    (r_state == S_DRD),
        .i_raddr ({r_j, rd_idx}),
        .o_rdata (din_rdata)
    );

    `SRF_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, r_state == S_CRD, "accepted transaction did not start the comb pass")
    `SRF_ASSERT_NOW(a_comb_index, r_state == S_CACC, r_k <= KW'(NUM_COMBS - 1), "comb index out of range")
    `SRF_ASSERT_NEXT(a_out_hold, r_state == S_OUT && r_out_valid && !m_axis_tready, r_state == S_OUT && $stable(r_wp), "pending result overwritten")
    `SRF_ASSERT_NEXT(a_wp_step, out_load, r_state == S_IDLE && r_wp != $past(r_wp), "write pointer did not advance with the result")

endmodule
